// File: src/secded_16_11_codec_defines.svh
// ---------------------------------------------------------------------------
// SECDED (16,11) codec assertion macros
// Shared property wrappers for the codec checker.
// ---------------------------------------------------------------------------
`ifndef SECDED_16_11_CODEC_DEFINES_SVH
`define SECDED_16_11_CODEC_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SECDED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define SECDED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/secded_pkg.sv
// ---------------------------------------------------------------------------
// SECDED (16,11) codec package
// Beat types, operation and status codes, check masks and syndrome map.
// ---------------------------------------------------------------------------
`default_nettype none

package secded_pkg;

  localparam int DataW = 11;
  localparam int WordW = 16;
  localparam int ChkW  = 4;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  localparam logic [1:0] STATUS_CLEAN     = 2'd0;
  localparam logic [1:0] STATUS_CORRECTED = 2'd1;
  localparam logic [1:0] STATUS_FAILED    = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [WordW-1:0] in_word;
  } req_t;

  typedef struct packed {
    logic [WordW-1:0] out_word;
    logic [1:0]       status;
  } rsp_t;

  localparam logic [DataW-1:0] ENC_MASK [ChkW] = '{
    11'b10101011011,
    11'b11001101101,
    11'b11110001110,
    11'b11111110000
  };

  localparam logic [WordW-1:0] DEC_MASK [ChkW] = '{
    16'b1010101101100001,
    16'b1100110110100010,
    16'b1111000111000100,
    16'b1111111000001000
  };

  // Codeword bit in error for each Hamming syndrome when overall parity is odd.
  function automatic logic [3:0] err_pos(input logic [3:0] syn);
    logic [3:0] pos;
    case (syn)
      4'd0:    pos = 4'd4;
      4'd1:    pos = 4'd0;
      4'd2:    pos = 4'd1;
      4'd3:    pos = 4'd5;
      4'd4:    pos = 4'd2;
      4'd5:    pos = 4'd6;
      4'd6:    pos = 4'd7;
      4'd7:    pos = 4'd8;
      4'd8:    pos = 4'd3;
      4'd9:    pos = 4'd9;
      4'd10:   pos = 4'd10;
      4'd11:   pos = 4'd11;
      4'd12:   pos = 4'd12;
      4'd13:   pos = 4'd13;
      4'd14:   pos = 4'd14;
      4'd15:   pos = 4'd15;
      default: pos = 4'd4;
    endcase
    return pos;
  endfunction

endpackage

`default_nettype wire

// File: src/secded_16_11_codec.sv
// ---------------------------------------------------------------------------
// SECDED (16,11) codec
// Extended Hamming encoder and single-error-correcting decoder.
// ---------------------------------------------------------------------------
// Usage:
//   Request beats arrive on req / req_valid / req_stall. req_type selects
//   encode (11 data bits in in_word[10:0]) or decode (16-bit codeword).
//   Response beats leave on rsp / rsp_valid / rsp_stall, one per request,
//   in order. Decode returns data in out_word[10:0] and a status of clean,
//   corrected or uncorrectable; encode returns the codeword with status clean.
//   From request accept to response valid, a beat passes an input
//   register, one level of XOR trees and syndrome correction, then the
//   response register. Throughput is one beat per cycle unless the receiver stalls.
//   When the receiver stalls, the response register holds its beat and the
//   input register fills; req_stall rises once both hold a beat, so no beat
//   is lost. Synchronous reset empties both stages; no response is valid in
//   the cycle after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module secded_16_11_codec (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire secded_pkg::req_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output secded_pkg::rsp_t      rsp
);

  logic             s1_valid;
  secded_pkg::req_t s1;
  logic             adv_out;
  logic             adv_in;
  secded_pkg::rsp_t rsp_next;

  logic [secded_pkg::DataW-1:0] data;
  logic [secded_pkg::ChkW-1:0]  chk;
  logic [secded_pkg::WordW-1:0] codeword;
  logic [secded_pkg::ChkW-1:0]  syn;
  logic                         overall;
  logic [secded_pkg::WordW-1:0] fixed;

  assign adv_out   = !rsp_valid || !rsp_stall;
  assign adv_in    = !s1_valid || adv_out;
  assign req_stall = !adv_in;

  always_comb begin
    data = s1.in_word[secded_pkg::DataW-1:0];
    for (int i = 0; i < secded_pkg::ChkW; i++) begin
      chk[i] = ^(data & secded_pkg::ENC_MASK[i]);
      syn[i] = ^(s1.in_word & secded_pkg::DEC_MASK[i]);
    end
    codeword = {data, ^{data, chk}, chk};
    overall  = ^s1.in_word;
    fixed    = s1.in_word;
    rsp_next = '0;
    if (s1.req_type == secded_pkg::OP_ENCODE) begin
      rsp_next.out_word = codeword;
      rsp_next.status   = secded_pkg::STATUS_CLEAN;
    end else begin
      if (overall) begin
        fixed[secded_pkg::err_pos(syn)] = ~s1.in_word[secded_pkg::err_pos(syn)];
        rsp_next.status = secded_pkg::STATUS_CORRECTED;
      end else if (syn != '0) begin
        rsp_next.status = secded_pkg::STATUS_FAILED;
      end else begin
        rsp_next.status = secded_pkg::STATUS_CLEAN;
      end
      rsp_next.out_word = {{(secded_pkg::WordW-secded_pkg::DataW){1'b0}},
                           fixed[secded_pkg::WordW-1:secded_pkg::WordW-secded_pkg::DataW]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (adv_in) begin
        s1_valid <= req_valid;
      end
      if (adv_out) begin
        rsp_valid <= s1_valid;
      end
    end
    if (adv_in && req_valid) begin
      s1 <= req;
    end
    if (adv_out && s1_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

// File: src/secded_chk.sv
// ---------------------------------------------------------------------------
// SECDED (16,11) codec checker
// Port-level properties of the codec pipeline, bound into the codec module.
// ---------------------------------------------------------------------------
`default_nettype none
`include "secded_16_11_codec_defines.svh"

module secded_chk (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_stall,
  input wire logic             rsp_valid,
  input wire logic             rsp_stall,
  input wire secded_pkg::rsp_t rsp
);

  `SECDED_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !rsp_valid, "response valid after reset")

  `SECDED_ASSERT(a_stall_cause, req_stall |-> rsp_valid && rsp_stall, "request stalled without cause")

  `SECDED_ASSERT(a_latency, req_valid && !req_stall ##1 !rsp_stall |=> rsp_valid, "response missing")

  `SECDED_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled beat changed")

endmodule

bind secded_16_11_codec secded_chk u_secded_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire

// File: test/secded_16_11_codec_tb.sv
// ---------------------------------------------------------------------------
// SECDED (16,11) codec testbench
// Drives encode and decode beats through the codec with random gaps and
// receiver stalls, including one long hold-off that backs up the request
// side. A directed table covers the extremes and each correction case,
// followed by random codewords with zero to three flipped bits, raw noise
// words and encodes with junk in the upper bits. Each response is compared
// with an in-order queue of predicted words and status codes.
// ---------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int RANDOM_BEATS = 1328;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 200;

  // Data bits feeding check bits 0..3.
  localparam logic [10:0] CHK_SEL [4] = '{11'h55B, 11'h66D, 11'h78E, 11'h7F0};
  // Codeword bits feeding syndrome bits 0..3.
  localparam logic [15:0] SYN_SEL [4] = '{16'hAB61, 16'hCDA2, 16'hF1C4, 16'hFE08};
  // Bit to flip for each syndrome when overall parity is odd.
  localparam logic [3:0] FLIP_POS [16] = '{
    4'd4, 4'd0, 4'd1, 4'd5, 4'd2, 4'd6, 4'd7, 4'd8,
    4'd3, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
  };

  typedef struct packed {
    logic        op;
    logic [15:0] word;
    logic        known;
    logic [15:0] exp_word;
    logic [1:0]  exp_status;
  } vec_t;

  localparam int NUM_DIRECTED = 22;
  localparam vec_t DIRECTED [NUM_DIRECTED] = '{
    '{secded_pkg::OP_ENCODE, 16'h0000, 1'b1, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_ENCODE, 16'h07FF, 1'b1, 16'hFFFF, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_ENCODE, 16'hFFFF, 1'b1, 16'hFFFF, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_ENCODE, 16'hF800, 1'b1, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_ENCODE, 16'h0555, 1'b0, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_ENCODE, 16'h02AA, 1'b0, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_ENCODE, 16'h0001, 1'b0, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_ENCODE, 16'h0400, 1'b0, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_DECODE, 16'h0000, 1'b1, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_DECODE, 16'hFFFF, 1'b1, 16'h07FF, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_DECODE, 16'h0010, 1'b1, 16'h0000, secded_pkg::STATUS_CORRECTED},
    '{secded_pkg::OP_DECODE, 16'hFFEF, 1'b1, 16'h07FF, secded_pkg::STATUS_CORRECTED},
    '{secded_pkg::OP_DECODE, 16'hFFFE, 1'b1, 16'h07FF, secded_pkg::STATUS_CORRECTED},
    '{secded_pkg::OP_DECODE, 16'h8000, 1'b1, 16'h0000, secded_pkg::STATUS_CORRECTED},
    '{secded_pkg::OP_DECODE, 16'h7FFF, 1'b1, 16'h07FF, secded_pkg::STATUS_CORRECTED},
    '{secded_pkg::OP_DECODE, 16'h0003, 1'b1, 16'h0000, secded_pkg::STATUS_FAILED},
    '{secded_pkg::OP_DECODE, 16'hC000, 1'b1, 16'h0600, secded_pkg::STATUS_FAILED},
    '{secded_pkg::OP_DECODE, 16'h3FFF, 1'b1, 16'h01FF, secded_pkg::STATUS_FAILED},
    '{secded_pkg::OP_DECODE, 16'h0020, 1'b0, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_DECODE, 16'h0100, 1'b0, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_DECODE, 16'h0007, 1'b0, 16'h0000, secded_pkg::STATUS_CLEAN},
    '{secded_pkg::OP_DECODE, 16'hA5A5, 1'b0, 16'h0000, secded_pkg::STATUS_CLEAN}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  secded_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  secded_pkg::rsp_t rsp;

  secded_pkg::rsp_t expected_rsp [$];
  int unsigned cycles = 0;
  int errors = 0;
  int beats_in = 0;
  int encodes = 0;
  int decodes = 0;
  int by_status [4] = '{0, 0, 0, 0};
  int held_cycles = 0;
  bit steady = 1'b0;
  bit hold_done = 1'b0;

  secded_16_11_codec dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] encode_word(input logic [10:0] d);
    logic [15:0] cw;
    int i;
    cw = {d, 5'b0};
    for (i = 0; i < 4; i++) cw[i] = ^(d & CHK_SEL[i]);
    cw[4] = ^cw;
    return cw;
  endfunction

  function automatic secded_pkg::rsp_t predict_codec(input secded_pkg::req_t r);
    secded_pkg::rsp_t p;
    logic [15:0] w;
    logic [3:0] syn;
    int i;
    p.status = secded_pkg::STATUS_CLEAN;
    if (r.req_type == secded_pkg::OP_ENCODE) begin
      p.out_word = encode_word(r.in_word[10:0]);
    end else begin
      w = r.in_word;
      for (i = 0; i < 4; i++) syn[i] = ^(w & SYN_SEL[i]);
      if (^w) begin
        w[FLIP_POS[syn]] = ~w[FLIP_POS[syn]];
        p.status = secded_pkg::STATUS_CORRECTED;
      end else if (syn != 4'd0) begin
        p.status = secded_pkg::STATUS_FAILED;
      end
      p.out_word = {5'b0, w[15:5]};
    end
    return p;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic secded_pkg::req_t random_req();
    secded_pkg::req_t r;
    logic [15:0] flips;
    int pick;
    int nflip;
    pick = $urandom_range(0, 99);
    r.req_type = secded_pkg::OP_DECODE;
    r.in_word = 16'($urandom);
    if (pick < 30) begin
      r.req_type = secded_pkg::OP_ENCODE;
    end else if (pick < 85) begin
      pick = $urandom_range(0, 99);
      nflip = (pick < 25) ? 0 : (pick < 70) ? 1 : (pick < 95) ? 2 : 3;
      flips = '0;
      while ($countones(flips) < nflip) flips[$urandom_range(0, 15)] = 1'b1;
      r.in_word = encode_word(r.in_word[10:0]) ^ flips;
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic send_beat(input secded_pkg::req_t r, input secded_pkg::rsp_t e);
    int gap;
    gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsp.push_back(e);
    beats_in++;
    if (r.req_type == secded_pkg::OP_ENCODE) encodes++;
    else decodes++;
    by_status[e.status]++;
  endtask

  initial begin : req_side
    secded_pkg::req_t r;
    secded_pkg::rsp_t e;
    int n;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (n = 0; n < NUM_DIRECTED; n++) begin
      r.req_type = DIRECTED[n].op;
      r.in_word = DIRECTED[n].word;
      if (DIRECTED[n].known) begin
        e.out_word = DIRECTED[n].exp_word;
        e.status = DIRECTED[n].exp_status;
      end else begin
        e = predict_codec(r);
      end
      send_beat(r, e);
    end
    for (n = 0; n < RANDOM_BEATS; n++) begin
      steady = (n >= 800 && n < 950);
      r = random_req();
      send_beat(r, predict_codec(r));
    end
    req_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d beats: %0d encodes, %0d decodes (%0d clean, %0d corrected, %0d bad)",
             beats_in, encodes, decodes,
             by_status[secded_pkg::STATUS_CLEAN] - encodes,
             by_status[secded_pkg::STATUS_CORRECTED],
             by_status[secded_pkg::STATUS_FAILED]);
    $display("request side held off %0d cycles, %0d mismatches", held_cycles, errors);
    if (errors == 0) begin
      $display("secded_16_11_codec regression: pass");
    end else begin
      $display("secded_16_11_codec regression: fail");
    end
    $finish;
  end

  // Hold the response side once for a long stretch so the codec backs up; otherwise stall it at random.
  initial begin : rsp_side
    forever begin
      @(posedge clk);
      if (!hold_done && beats_in >= HOLD_AT) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        rsp_stall <= 1'b0;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b1;
        repeat (idle_len() - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    secded_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        flag_error($sformatf("unexpected beat: out_word %h status %0d", rsp.out_word,
                             rsp.status));
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.out_word !== want.out_word || rsp.status !== want.status) begin
          flag_error($sformatf("mismatch: out_word %h (want %h) status %0d (want %0d)",
                               rsp.out_word, want.out_word, rsp.status, want.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && req_valid && req_stall) held_cycles <= held_cycles + 1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("secded_16_11_codec regression: fail");
      $finish;
    end
  end

endmodule

// File: sim.f
+incdir+src
src/secded_pkg.sv
src/secded_16_11_codec.sv
src/secded_chk.sv
test/secded_16_11_codec_tb.sv
